[hw/rtl/art2a_pkg.sv]
// Package for the ART-2A clustering block: status codes, register indexes,
// controller command/status structs. No dependencies.
package art2a_pkg;
	localparam logic [1:0] ST_MATCH = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] REG_VIGILANCE = 2'd0;
	localparam logic [1:0] REG_MATCH     = 2'd1;
	localparam logic [1:0] REG_LEARN     = 2'd2;

	localparam int unsigned CFG_W = 17;
	localparam logic [16:0] Q16_ONE = 17'h10000;

	// controller -> datapath
	typedef struct packed {
		logic take;      // store incoming element
		logic clr_acc;   // clear dot product accumulator
		logic mac;       // accumulate product of last read pair
		logic judge;     // compare finished activation with best
		logic rd;        // issue weight read
		logic wr;        // write weight word
		logic wsel;      // 1: write blended value, 0: write sample
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic found;
	} dp_sts_t;
endpackage

[hw/rtl/art2a_ram.sv]
// Generic single-port RAM with registered read. No dependencies.
module art2a_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[hw/rtl/art2a_dp.sv]
// Datapath: sample buffer, weight memory, MAC, qualify/argmax, blend.
// Depends on art2a_pkg and art2a_ram.
module art2a_dp #(
	parameter int FEATURE_DIM = 16,
	parameter int MAX_CATEGORIES = 64,
	localparam int FW = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1,
	localparam int CW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1,
	localparam int AW = $clog2(FEATURE_DIM * MAX_CATEGORIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  art2a_pkg::dp_cmd_t  cmd,
	input  logic [FW-1:0]       elem,      // element being taken or read
	input  logic [CW-1:0]       row,       // category row addressed
	input  logic                first_elem,
	input  logic                predict,
	input  logic [CW-1:0]       judge_row,
	input  logic [15:0]         sample_value,
	input  logic [16:0]         vigilance,
	input  logic [16:0]         match_scale,
	input  logic [16:0]         learn_rate,
	output logic [CW-1:0]       best_row,
	output art2a_pkg::dp_sts_t  sts
);
	localparam int SW = 16 + FW + 1;
	localparam int ACW = 33 + FW;
	localparam logic [16:0] Q16_ONE_c = art2a_pkg::Q16_ONE;

	logic signed [15:0] buf_q [FEATURE_DIM];
	logic signed [SW-1:0] sum_q;
	logic signed [ACW-1:0] acc_q, best_q;
	logic found_q;
	logic [CW-1:0] best_row_q;
	logic [15:0] rdata, wdata;
	logic [FW-1:0] elem_s1;
	logic [AW-1:0] addr_full;
	logic signed [31:0] prod;
	logic signed [ACW-1:0] act;
	logic q_ok, better;
	logic signed [49:0] need, act2;
	logic signed [35:0] blend;
	logic signed [35:0] bx, bw;
	logic signed [19:0] rnd;

	// hold sample buffer and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sum_q <= '0;
		else if (cmd.take)
			sum_q <= (first_elem ? SW'(0) : sum_q) + SW'($signed(sample_value));
	end
	always_ff @(posedge clk) if (cmd.take) buf_q[elem] <= sample_value;

	// address the weight store
	assign addr_full = AW'(row) * AW'(FEATURE_DIM) + AW'(elem);

	// blend: (b*x + (1-b)*w + 2^15) >> 16, saturated; w is the word read last cycle
	assign bx = $signed({1'b0, learn_rate}) * buf_q[elem];
	assign bw = $signed({1'b0, 17'(Q16_ONE_c - learn_rate)}) * $signed(rdata);
	assign blend = bx + bw + 36'sd32768;
	assign rnd = 20'(blend >>> 16);
	always_comb begin
		if (rnd > 20'sd32767) wdata = 16'h7fff;
		else if (rnd < -20'sd32768) wdata = 16'h8000;
		else wdata = rnd[15:0];
		if (!cmd.wsel) wdata = buf_q[elem];
	end

	art2a_ram #(.WIDTH(16), .DEPTH(FEATURE_DIM * MAX_CATEGORIES)) u_ram (
		.clk(clk), .we(cmd.wr), .addr(addr_full[$clog2(FEATURE_DIM*MAX_CATEGORIES)-1:0]),
		.wdata(wdata), .rdata(rdata)
	);

	// accumulate dot product one element per cycle
	always_ff @(posedge clk) if (cmd.rd) elem_s1 <= elem;
	assign prod = buf_q[elem_s1] * $signed(rdata);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else if (cmd.clr_acc) acc_q <= '0;
		else if (cmd.mac) acc_q <= acc_q + ACW'(prod);
	end
	// fold in the product that lands in the judge cycle
	assign act = acc_q + (cmd.mac ? ACW'(prod) : ACW'(0));

	// qualify and track the best row
	assign need = $signed({1'b0, match_scale}) * 50'(sum_q);
	assign act2 = 50'(act) <<< 1;
	assign q_ok = predict || ((50'(act) >= $signed({19'd0, vigilance, 14'd0}))
		&& (act2 >= need));
	assign better = !found_q || (act > best_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_row_q <= '0;
		end else if (cmd.take && first_elem) begin
			found_q <= 1'b0;
			best_row_q <= '0;
		end else if (cmd.judge && q_ok && better) begin
			found_q <= 1'b1;
			best_row_q <= judge_row;
		end
	end
	always_ff @(posedge clk) if (cmd.judge && q_ok && better) best_q <= act;

	assign best_row = best_row_q;
	assign sts.found = found_q;
endmodule

[hw/rtl/art2a_ctrl.sv]
// Controller: element count, row scan, update sequencing, result word.
// Depends on art2a_pkg.
module art2a_ctrl #(
	parameter int FEATURE_DIM = 16,
	parameter int MAX_CATEGORIES = 64,
	localparam int FW = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1,
	localparam int CW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1,
	localparam int NW = $clog2(MAX_CATEGORIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [5:0]          category,
	output logic [1:0]          status,
	output art2a_pkg::dp_cmd_t  cmd,
	output logic [FW-1:0]       elem,
	output logic [CW-1:0]       row,
	output logic                first_elem,
	output logic                predict,
	output logic [CW-1:0]       judge_row,
	input  logic [CW-1:0]       best_row,
	input  art2a_pkg::dp_sts_t  sts
);
	localparam logic [2:0] S_COLLECT = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_JUDGE   = 3'd2;
	localparam logic [2:0] S_DECIDE  = 3'd3;
	localparam logic [2:0] S_BLEND   = 3'd4;
	localparam logic [2:0] S_STORE   = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0] state_q;
	logic [FW-1:0] idx_q, ridx_q;
	logic [CW-1:0] row_q;
	logic [NW-1:0] count_q;
	logic mode_q, mac_q, last_q, bph_q;
	logic [5:0] cat_q;
	logic [1:0] st_q;
	logic acc_in;
	logic [CW-1:0] tgt_q;

	assign in_stall = (state_q != S_COLLECT);
	assign acc_in = in_valid && !in_stall;
	assign first_elem = (idx_q == '0);
	assign predict = mode_q;
	assign out_valid = (state_q == S_OUT);
	assign category = cat_q;
	assign status = st_q;
	assign judge_row = row_q;

	// drive commands
	always_comb begin
		cmd = '0;
		elem = idx_q;
		row = row_q;
		cmd.take = acc_in;
		cmd.mac = mac_q;
		cmd.judge = (state_q == S_JUDGE);
		cmd.clr_acc = (state_q == S_JUDGE);
		unique case (state_q)
			S_SCAN: begin
				cmd.rd = 1'b1;
				elem = ridx_q;
			end
			S_BLEND: begin
				elem = ridx_q;
				row = tgt_q;
				cmd.wsel = 1'b1;
				cmd.wr = bph_q;
			end
			S_STORE: begin
				elem = ridx_q;
				row = tgt_q;
				cmd.wr = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			idx_q <= '0;
			ridx_q <= '0;
			row_q <= '0;
			count_q <= '0;
			mode_q <= 1'b0;
			mac_q <= 1'b0;
			last_q <= 1'b0;
			bph_q <= 1'b0;
			cat_q <= '0;
			st_q <= '0;
			tgt_q <= '0;
		end else begin
			mac_q <= (state_q == S_SCAN);
			unique case (state_q)
				S_COLLECT: if (acc_in) begin
					if (first_elem) mode_q <= req_type;
					ridx_q <= '0;
					row_q <= '0;
					if (32'(idx_q) == FEATURE_DIM - 1) begin
						idx_q <= '0;
						if (count_q == '0) begin
							cat_q <= '0;
							st_q <= req_type && FEATURE_DIM == 1 || mode_q && FEATURE_DIM > 1
								? art2a_pkg::ST_EMPTY : art2a_pkg::ST_NEW;
							tgt_q <= '0;
							if ((FEATURE_DIM == 1) ? req_type : mode_q) state_q <= S_OUT;
							else begin
								count_q <= NW'(1);
								state_q <= S_STORE;
							end
						end else state_q <= S_SCAN;
					end else idx_q <= idx_q + FW'(1);
				end
				S_SCAN: begin
					if (32'(ridx_q) == FEATURE_DIM - 1) begin
						ridx_q <= '0;
						state_q <= S_JUDGE;
						last_q <= (32'(row_q) + 1 == 32'(count_q));
					end else ridx_q <= ridx_q + FW'(1);
				end
				S_JUDGE: begin
					if (mac_q) ; // last product lands this cycle
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!last_q) begin
						row_q <= row_q + CW'(1);
						state_q <= S_SCAN;
					end else if (sts.found || mode_q) begin
						cat_q <= 6'(best_row);
						st_q <= art2a_pkg::ST_MATCH;
						tgt_q <= best_row;
						bph_q <= 1'b0;
						state_q <= mode_q ? S_OUT : S_BLEND;
					end else if (32'(count_q) < MAX_CATEGORIES) begin
						cat_q <= 6'(count_q);
						st_q <= art2a_pkg::ST_NEW;
						tgt_q <= CW'(count_q);
						count_q <= count_q + NW'(1);
						state_q <= S_STORE;
					end else begin
						cat_q <= '0;
						st_q <= art2a_pkg::ST_FULL;
						state_q <= S_OUT;
					end
				end
				S_BLEND: begin
					// read phase then write phase per element
					bph_q <= !bph_q;
					if (bph_q) begin
						if (32'(ridx_q) == FEATURE_DIM - 1) begin
							ridx_q <= '0;
							state_q <= S_OUT;
						end else ridx_q <= ridx_q + FW'(1);
					end
				end
				S_STORE: begin
					if (32'(ridx_q) == FEATURE_DIM - 1) begin
						ridx_q <= '0;
						state_q <= S_OUT;
					end else ridx_q <= ridx_q + FW'(1);
				end
				S_OUT: if (!out_stall) state_q <= S_COLLECT;
				default: state_q <= S_COLLECT;
			endcase
		end
	end
endmodule

[hw/rtl/art2a_online_clustering_top.sv]
// After the last element the block scans every stored row (one memory read and
// one MAC per cycle); when learning it then stores a new row or blends the
// matched row (a read then a write per element). The result word follows.
// Elements are taken one per cycle while collecting a sample.
// Reset clears counts and control, presets config; weight RAM is not cleared.
module art2a_online_clustering_top #(
	parameter int FEATURE_DIM = 16,
	parameter int MAX_CATEGORIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] sample_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  category,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	localparam int FW = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
	localparam int CW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;

	logic [16:0] vig_q, mat_q, lrn_q, clamped;
	art2a_pkg::dp_cmd_t cmd;
	art2a_pkg::dp_sts_t sts;
	logic [FW-1:0] elem;
	logic [CW-1:0] row, judge_row, best_row;
	logic first_elem, predict;

	// clamp and hold configuration words
	assign clamped = (cfg_data > art2a_pkg::Q16_ONE) ? art2a_pkg::Q16_ONE : cfg_data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vig_q <= 17'd58982;
			mat_q <= 17'd0;
			lrn_q <= 17'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				art2a_pkg::REG_VIGILANCE: vig_q <= clamped;
				art2a_pkg::REG_MATCH:     mat_q <= clamped;
				art2a_pkg::REG_LEARN:     lrn_q <= clamped;
				default: ;
			endcase
		end
	end

	art2a_ctrl #(.FEATURE_DIM(FEATURE_DIM), .MAX_CATEGORIES(MAX_CATEGORIES)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .out_valid, .out_stall,
		.category, .status, .cmd, .elem, .row, .first_elem, .predict,
		.judge_row, .best_row, .sts
	);

	art2a_dp #(.FEATURE_DIM(FEATURE_DIM), .MAX_CATEGORIES(MAX_CATEGORIES)) u_dp (
		.clk, .arst_n, .cmd, .elem, .row, .first_elem, .predict, .judge_row,
		.sample_value, .vigilance(vig_q), .match_scale(mat_q), .learn_rate(lrn_q),
		.best_row, .sts
	);
endmodule

[hw/rtl/art2a_checker.sv]
// Port-level checker for the clustering top level, with its bind.
// Depends on art2a_pkg.
module art2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] category,
	input logic [1:0] status
);
	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(category) && $stable(status))
		else $error("result changed under stall");
	// no element taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open with result pending");
	// table full reports category zero
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == art2a_pkg::ST_FULL |-> category == 6'd0)
		else $error("full status with nonzero category");
endmodule

bind art2a_online_clustering_top art2a_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .category, .status
);

[test/tb_art2a_online_clustering_top.sv]
// Testbench for art2a_online_clustering_top: drives sample elements, predicts
// category and status with an in-bench clustering model. Depends on art2a_pkg.

class cluster_scoreboard;
	localparam int DIM = 16;
	localparam int NCAT = 64;

	int errors;
	logic [16:0] rho, alpha, beta;
	int weights [NCAT][DIM];
	int sample [DIM];
	int cat_count;
	int elem_idx;
	longint elem_sum;
	bit mode_predict;
	logic [5:0] cat_q [$];
	logic [1:0] status_q [$];

	function new();
		errors = 0;
		rho = 17'd58982;
		alpha = 17'd0;
		beta = 17'd32768;
		cat_count = 0;
		elem_idx = 0;
		elem_sum = 0;
		mode_predict = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [16:0] val);
		logic [16:0] v;
		v = (val > art2a_pkg::Q16_ONE) ? art2a_pkg::Q16_ONE : val;
		case (idx)
			art2a_pkg::REG_VIGILANCE: rho = v;
			art2a_pkg::REG_MATCH: alpha = v;
			art2a_pkg::REG_LEARN: beta = v;
			default: ;
		endcase
	endfunction

	function longint activation(int c);
		longint acc;
		acc = 0;
		for (int j = 0; j < DIM; j++)
			acc += longint'(sample[j]) * longint'(weights[c][j]);
		return acc;
	endfunction

	// note one accepted element; queue a result after the last one
	function void note_word(logic rtype, logic signed [15:0] value);
		longint a, best, rho30, need31, t, r;
		int cat;
		logic [1:0] st;
		bit found;
		if (elem_idx == 0) begin
			mode_predict = rtype;
			elem_sum = 0;
		end
		sample[elem_idx] = int'(value);
		elem_sum += longint'(value);
		if (elem_idx + 1 < DIM) begin
			elem_idx++;
			return;
		end
		elem_idx = 0;
		cat = 0;
		st = art2a_pkg::ST_MATCH;
		if (mode_predict) begin
			if (cat_count == 0) begin
				st = art2a_pkg::ST_EMPTY;
			end else begin
				best = activation(0);
				for (int c = 1; c < cat_count; c++) begin
					a = activation(c);
					if (a > best) begin
						best = a;
						cat = c;
					end
				end
			end
		end else if (cat_count == 0) begin
			for (int j = 0; j < DIM; j++) weights[0][j] = sample[j];
			cat_count = 1;
			st = art2a_pkg::ST_NEW;
		end else begin
			found = 0;
			best = 0;
			rho30 = longint'(rho) * 16384;
			need31 = longint'(alpha) * elem_sum;
			for (int c = 0; c < cat_count; c++) begin
				a = activation(c);
				if (a >= rho30 && 2 * a >= need31 && (!found || a > best)) begin
					found = 1;
					best = a;
					cat = c;
				end
			end
			if (found) begin
				// blend toward the sample, round half up, saturate
				for (int j = 0; j < DIM; j++) begin
					t = longint'(beta) * sample[j]
						+ (65536 - longint'(beta)) * weights[cat][j] + 32768;
					r = t >>> 16;
					if (r > 32767) r = 32767;
					if (r < -32768) r = -32768;
					weights[cat][j] = int'(r);
				end
			end else if (cat_count < NCAT) begin
				cat = cat_count;
				for (int j = 0; j < DIM; j++) weights[cat][j] = sample[j];
				cat_count++;
				st = art2a_pkg::ST_NEW;
			end else begin
				cat = 0;
				st = art2a_pkg::ST_FULL;
			end
		end
		cat_q = {cat_q, cat[5:0]};
		status_q = {status_q, st};
	endfunction

	function void check_word(logic [5:0] cat, logic [1:0] st);
		logic [5:0] ec;
		logic [1:0] es;
		if (cat_q.size() == 0) begin
			$error("unexpected result word category=%0d status=%0d", cat, st);
			errors++;
			return;
		end
		ec = cat_q.pop_front();
		es = status_q.pop_front();
		if (cat !== ec) begin
			$error("category: expected %0d actual %0d", ec, cat);
			errors++;
		end
		if (st !== es) begin
			$error("status: expected %0d actual %0d", es, st);
			errors++;
		end
	endfunction

	function int pending();
		return cat_q.size();
	endfunction
endclass

module tb_art2a_online_clustering_top;
	localparam int DIM = 16;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic req_type = 0;
	logic [15:0] sample_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [5:0] category;
	logic [1:0] status;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	cluster_scoreboard board;
	bit hold_long = 0;
	int stall_mode = 0;
	logic signed [15:0] proto [8][DIM];

	art2a_online_clustering_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .sample_value(sample_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.category(category), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// check every accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(category, status);
	end

	// receiver stall pattern; a long hold-off when asked
	always @(posedge clk) begin
		if (hold_long)
			out_stall <= 1;
		else case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// offer one element, hold it until accepted; drop valid only for a gap
	task automatic send_word(logic rtype, logic [15:0] value, bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= rtype;
		sample_value <= value;
		do @(posedge clk); while (in_stall);
		board.note_word(rtype, value);
	endtask

	// send a whole sample; elements are consecutive words
	task automatic send_sample(logic rtype, logic signed [15:0] vals [DIM], bit gaps);
		for (int j = 0; j < DIM; j++)
			send_word(j == 0 ? rtype : logic'($urandom_range(0, 1)), vals[j], gaps);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (board.pending() != 0) @(posedge clk);
		// cover the longest scan with a blend after the last result
		while (guard < 64 * (DIM + 2) + 3 * DIM + 20) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random sample: near a prototype, pure noise or an extreme
	task automatic make_sample(output logic signed [15:0] vals [DIM]);
		int kind, p, v;
		kind = $urandom_range(0, 9);
		p = $urandom_range(0, 7);
		for (int j = 0; j < DIM; j++) begin
			if (kind < 7) begin
				v = int'(proto[p][j]) + $signed($urandom_range(0, 2047)) - 1024;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				vals[j] = v[15:0];
			end else if (kind < 9) begin
				vals[j] = 16'($urandom_range(0, 65535));
			end else begin
				vals[j] = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
			end
		end
	endtask

	task automatic random_phase(int nsamples, logic [16:0] r, logic [16:0] a,
			logic [16:0] b);
		logic signed [15:0] vals [DIM];
		write_reg(art2a_pkg::REG_VIGILANCE, r);
		write_reg(art2a_pkg::REG_MATCH, a);
		write_reg(art2a_pkg::REG_LEARN, b);
		for (int s = 0; s < nsamples; s++) begin
			stall_mode = $urandom_range(0, 2);
			make_sample(vals);
			send_sample(logic'($urandom_range(0, 3) == 0), vals, 1'b1);
		end
		drain();
	endtask

	initial begin
		logic signed [15:0] vals [DIM];
		board = new();
		for (int p = 0; p < 8; p++)
			for (int j = 0; j < DIM; j++)
				proto[p][j] = 16'($signed($urandom_range(0, 16383)) - 8192);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: predict on empty table, first fit, extremes
		for (int j = 0; j < DIM; j++) vals[j] = 16'sh7fff;
		send_sample(1'b1, vals, 1'b0);
		send_sample(1'b0, vals, 1'b0);
		for (int j = 0; j < DIM; j++) vals[j] = 16'sh8000;
		send_sample(1'b0, vals, 1'b0);
		send_sample(1'b1, vals, 1'b0);
		drain();
		write_reg(art2a_pkg::REG_VIGILANCE, 17'h1ffff);
		write_reg(art2a_pkg::REG_MATCH, 17'h10000);
		write_reg(art2a_pkg::REG_LEARN, 17'h10000);
		write_reg(REG_UNUSED, 17'h00123);
		for (int j = 0; j < DIM; j++) vals[j] = 16'sh7fff;
		send_sample(1'b0, vals, 1'b0);
		drain();
		write_reg(art2a_pkg::REG_VIGILANCE, 17'd0);
		write_reg(art2a_pkg::REG_LEARN, 17'd0);
		write_reg(art2a_pkg::REG_MATCH, 17'd0);
		send_sample(1'b0, vals, 1'b0);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_long = 1;
		fork
			begin
				repeat (3) begin
					make_sample(vals);
					send_sample(1'b0, vals, 1'b0);
				end
			end
			begin
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end
		join
		drain();

		// random phases over several settings; tight vigilance adds categories
		random_phase(10, 17'd58982, 17'd0, 17'd32768);
		random_phase(10, 17'd0, 17'd65536, 17'd65535);
		random_phase(9, 17'h1ffff, 17'd0, 17'd1);
		random_phase(6, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)));
		random_phase(6, 17'd16384, 17'd0, 17'd0);

		if (board.errors == 0)
			$display("tb_art2a_online_clustering_top passed");
		else
			$display("tb_art2a_online_clustering_top failed");
		$finish;
	end

	// guard against a hung block
	initial begin
		#100000000;
		$display("tb_art2a_online_clustering_top failed");
		$finish;
	end
endmodule
